[design/cae_pkg.sv]
// shared types, constants and helpers for the column aggregate engine
package cae_pkg;

  localparam int PRICE_W = 32;
  localparam int QTY_W   = 32;
  localparam int SUM_W   = 64;

  localparam logic [SUM_W-1:0]   S64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0]   S64_MIN     = 64'h8000_0000_0000_0000;
  localparam logic [PRICE_W-1:0] S32_MAX     = 32'h7FFF_FFFF;
  localparam logic [PRICE_W-1:0] S32_MIN     = 32'h8000_0000;
  localparam logic [SUM_W-1:0]   AVG_POS_LIM = 64'h0000_0000_7FFF_FFFF;
  localparam logic [SUM_W-1:0]   AVG_NEG_LIM = 64'h0000_0000_8000_0000;

  // controller to datapath
  typedef struct packed {
    logic div_start;
    logic load_out;
  } cae_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_done;
    logic div_done;
  } cae_status_t;

  function automatic logic [SUM_W-1:0] sat_add64(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W-1:0] r;
    r = a + b;
    if ((a[SUM_W-1] == b[SUM_W-1]) && (r[SUM_W-1] != a[SUM_W-1])) begin
      r = a[SUM_W-1] ? S64_MIN : S64_MAX;
    end
    return r;
  endfunction

endpackage

[design/cae_if.sv]
// row and result channel interfaces

interface cae_in_if import cae_pkg::*; #(
  parameter int DISCOUNT_FRAC_BITS = 16
) ();
  logic                             valid;
  logic                             ready;
  logic signed [PRICE_W-1:0]        price;
  logic [DISCOUNT_FRAC_BITS:0]      discount;
  logic signed [QTY_W-1:0]          quantity;
  logic                             selected;
  logic                             last_row;

  modport source (output valid, price, discount, quantity, selected, last_row,
                  input ready);
  modport sink   (input valid, price, discount, quantity, selected, last_row,
                  output ready);
endinterface

interface cae_out_if import cae_pkg::*; #(
  parameter int COUNT_BITS = 40
) ();
  logic                      valid;
  logic                      ready;
  logic [COUNT_BITS-1:0]     sel_count;
  logic signed [SUM_W-1:0]   price_sum;
  logic signed [PRICE_W-1:0] price_min;
  logic signed [PRICE_W-1:0] price_max;
  logic signed [PRICE_W-1:0] price_avg;
  logic signed [SUM_W-1:0]   quantity_sum;
  logic signed [SUM_W-1:0]   net_sales_sum;

  modport source (output valid, sel_count, price_sum, price_min, price_max,
                  price_avg, quantity_sum, net_sales_sum,
                  input ready);
  modport sink   (input valid, sel_count, price_sum, price_min, price_max,
                  price_avg, quantity_sum, net_sales_sum,
                  output ready);
endinterface

[design/column_aggregate_engine.sv]
// Scalar aggregate over a stream of table rows (count, sums, min, max, average).
// Rows are taken one per cycle while a query is open. A selected row passes a
// five-stage net sale pipeline (price times one minus discount, then times
// quantity in two partial products, floor shift) before it reaches the
// accumulators. Once a row with last_row is taken, intake stops until the
// pipeline drains, the average runs through a one-bit-per-cycle restoring
// divider and the result word is loaded into the output register. The result
// can wait in the output register while the rows of the next query flow in.
module column_aggregate_engine import cae_pkg::*; #(
  parameter int COUNT_BITS         = 40,
  parameter int DISCOUNT_FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  cae_in_if.sink   in_ch,
  cae_out_if.source out_ch
);

  cae_cmd_t    cmd;
  cae_status_t status;
  logic        in_ready;
  logic        in_accept;

  assign in_accept   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  cae_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_last_row (in_ch.last_row),
    .out_ready   (out_ch.ready),
    .status      (status),
    .in_ready    (in_ready),
    .out_valid   (out_ch.valid),
    .cmd         (cmd)
  );

  cae_dp #(
    .COUNT_BITS         (COUNT_BITS),
    .DISCOUNT_FRAC_BITS (DISCOUNT_FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_accept         (in_accept),
    .in_price          (in_ch.price),
    .in_discount       (in_ch.discount),
    .in_quantity       (in_ch.quantity),
    .in_selected       (in_ch.selected),
    .in_last_row       (in_ch.last_row),
    .cmd               (cmd),
    .status            (status),
    .out_sel_count     (out_ch.sel_count),
    .out_price_sum     (out_ch.price_sum),
    .out_price_min     (out_ch.price_min),
    .out_price_max     (out_ch.price_max),
    .out_price_avg     (out_ch.price_avg),
    .out_quantity_sum  (out_ch.quantity_sum),
    .out_net_sales_sum (out_ch.net_sales_sum)
  );

endmodule

[design/cae_div.sv]
// restoring divider, one quotient bit per cycle, unsigned 64-bit dividend
module cae_div import cae_pkg::*; #(
  parameter int DIVISOR_BITS = 40
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [SUM_W-1:0]        dividend,
  input  logic [DIVISOR_BITS-1:0] divisor,
  output logic                    done,
  output logic [SUM_W-1:0]        quotient
);

  localparam int CW = $clog2(SUM_W);
  localparam logic [CW-1:0] LAST_STEP = CW'(SUM_W - 1);

  logic                    busy_r;
  logic                    done_r;
  logic [CW-1:0]           step_r;
  logic [SUM_W-1:0]        quot_r;
  logic [DIVISOR_BITS-1:0] rem_r;
  logic [DIVISOR_BITS-1:0] divisor_r;
  logic [DIVISOR_BITS:0]   shifted;
  logic                    ge;
  logic [DIVISOR_BITS-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, quot_r[SUM_W-1]};
    ge      = shifted >= {1'b0, divisor_r};
    rem_nxt = ge ? DIVISOR_BITS'(shifted - {1'b0, divisor_r})
                 : shifted[DIVISOR_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == LAST_STEP);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // dividend bits shift out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      quot_r    <= dividend;
      rem_r     <= '0;
      divisor_r <= divisor;
    end else if (busy_r) begin
      quot_r <= {quot_r[SUM_W-2:0], ge};
      rem_r  <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

[design/cae_dp.sv]
// datapath: net sale pipeline, accumulators, average divider, result word
module cae_dp import cae_pkg::*; #(
  parameter int COUNT_BITS         = 40,
  parameter int DISCOUNT_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_accept,
  input  logic signed [PRICE_W-1:0]   in_price,
  input  logic [DISCOUNT_FRAC_BITS:0] in_discount,
  input  logic signed [QTY_W-1:0]     in_quantity,
  input  logic                        in_selected,
  input  logic                        in_last_row,
  input  cae_cmd_t                    cmd,
  output cae_status_t                 status,
  output logic [COUNT_BITS-1:0]       out_sel_count,
  output logic signed [SUM_W-1:0]     out_price_sum,
  output logic signed [PRICE_W-1:0]   out_price_min,
  output logic signed [PRICE_W-1:0]   out_price_max,
  output logic signed [PRICE_W-1:0]   out_price_avg,
  output logic signed [SUM_W-1:0]     out_quantity_sum,
  output logic signed [SUM_W-1:0]     out_net_sales_sum
);

  localparam int DFB = DISCOUNT_FRAC_BITS;
  localparam int AW  = PRICE_W + DFB + 2;  // signed price * (one - discount)
  localparam int MW  = PRICE_W + DFB;      // its magnitude
  localparam int HW  = MW - 32;            // upper slice of the magnitude
  localparam int PW  = MW + QTY_W;         // full magnitude product
  localparam logic [DFB:0] ONE_V = {1'b1, {DFB{1'b0}}};

  // stage a: discount clamp and first product
  logic [DFB:0]             one_minus;
  logic signed [AW-1:0]     a_prod_nxt;
  logic                     a_vld_r, a_sel_r, a_last_r;
  logic signed [AW-1:0]     a_prod_r;
  logic signed [PRICE_W-1:0] a_price_r;
  logic signed [QTY_W-1:0]  a_qty_r;

  // stage b: magnitudes and sign
  logic                     b_vld_r, b_sel_r, b_last_r, b_neg_r;
  logic [MW-1:0]            b_am_r;
  logic [QTY_W-1:0]         b_qm_r;
  logic signed [PRICE_W-1:0] b_price_r;
  logic signed [QTY_W-1:0]  b_qty_r;

  // stage c: partial products
  logic                     c_vld_r, c_sel_r, c_last_r, c_neg_r;
  logic [63:0]              c_p0_r;
  logic [HW+QTY_W-1:0]      c_p1_r;
  logic signed [PRICE_W-1:0] c_price_r;
  logic signed [QTY_W-1:0]  c_qty_r;

  // stage d: combined product with floor bias
  logic                     d_vld_r, d_sel_r, d_last_r, d_neg_r;
  logic [PW-1:0]            d_sum_r;
  logic signed [PRICE_W-1:0] d_price_r;
  logic signed [QTY_W-1:0]  d_qty_r;

  // stage e: signed net term
  logic [SUM_W-1:0]         d_mag;
  logic                     e_vld_r, e_sel_r, e_last_r;
  logic [SUM_W-1:0]         e_term_r;
  logic signed [PRICE_W-1:0] e_price_r;
  logic signed [QTY_W-1:0]  e_qty_r;

  // accumulators
  logic [COUNT_BITS-1:0]    count_acc_r;
  logic [SUM_W-1:0]         price_acc_r;
  logic signed [PRICE_W-1:0] min_acc_r;
  logic signed [PRICE_W-1:0] max_acc_r;
  logic [SUM_W-1:0]         qty_acc_r;
  logic [SUM_W-1:0]         net_acc_r;
  logic                     last_done_r;

  // average
  logic [SUM_W-1:0]         avg_mag;
  logic                     avg_neg_r;
  logic                     div_done;
  logic [SUM_W-1:0]         quotient;
  logic [PRICE_W-1:0]       avg_val;

  // result word
  logic [COUNT_BITS-1:0]    out_count_r;
  logic [SUM_W-1:0]         out_psum_r;
  logic signed [PRICE_W-1:0] out_min_r;
  logic signed [PRICE_W-1:0] out_max_r;
  logic [PRICE_W-1:0]       out_avg_r;
  logic [SUM_W-1:0]         out_qsum_r;
  logic [SUM_W-1:0]         out_nsum_r;

  always_comb begin
    // a discount above one counts as one
    one_minus  = in_discount[DFB] ? '0 : (ONE_V - in_discount);
    a_prod_nxt = AW'(in_price) * AW'($signed({1'b0, one_minus}));
    d_mag      = d_sum_r[PW-1:DFB];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_accept;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_prod_r  <= a_prod_nxt;
    a_price_r <= in_price;
    a_qty_r   <= in_quantity;
    a_sel_r   <= in_selected;
    a_last_r  <= in_last_row;

    b_am_r    <= a_prod_r[AW-1] ? MW'(-a_prod_r) : MW'(a_prod_r);
    b_qm_r    <= a_qty_r[QTY_W-1] ? QTY_W'(-a_qty_r) : QTY_W'(a_qty_r);
    b_neg_r   <= (a_prod_r[AW-1] != a_qty_r[QTY_W-1]) && (a_prod_r != '0)
                 && (a_qty_r != '0);
    b_price_r <= a_price_r;
    b_qty_r   <= a_qty_r;
    b_sel_r   <= a_sel_r;
    b_last_r  <= a_last_r;

    c_p0_r    <= b_am_r[31:0] * b_qm_r;
    c_p1_r    <= b_am_r[MW-1:32] * b_qm_r;
    c_neg_r   <= b_neg_r;
    c_price_r <= b_price_r;
    c_qty_r   <= b_qty_r;
    c_sel_r   <= b_sel_r;
    c_last_r  <= b_last_r;

    // negative terms get one-minus-ulp added so the shift floors
    d_sum_r   <= {{DFB{1'b0}}, c_p0_r} + {c_p1_r, 32'b0}
                 + (c_neg_r ? PW'({DFB{1'b1}}) : PW'(0));
    d_neg_r   <= c_neg_r;
    d_price_r <= c_price_r;
    d_qty_r   <= c_qty_r;
    d_sel_r   <= c_sel_r;
    d_last_r  <= c_last_r;

    e_term_r  <= d_neg_r ? (~d_mag + 1'b1) : d_mag;
    e_price_r <= d_price_r;
    e_qty_r   <= d_qty_r;
    e_sel_r   <= d_sel_r;
    e_last_r  <= d_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_acc_r <= '0;
      price_acc_r <= '0;
      min_acc_r   <= S32_MAX;
      max_acc_r   <= S32_MIN;
      qty_acc_r   <= '0;
      net_acc_r   <= '0;
      last_done_r <= 1'b0;
    end else begin
      last_done_r <= e_vld_r && e_last_r;
      if (cmd.load_out) begin
        count_acc_r <= '0;
        price_acc_r <= '0;
        min_acc_r   <= S32_MAX;
        max_acc_r   <= S32_MIN;
        qty_acc_r   <= '0;
        net_acc_r   <= '0;
      end else if (e_vld_r && e_sel_r) begin
        if (count_acc_r != '1) begin
          count_acc_r <= count_acc_r + 1'b1;
        end
        price_acc_r <= sat_add64(price_acc_r, SUM_W'(e_price_r));
        qty_acc_r   <= sat_add64(qty_acc_r, SUM_W'(e_qty_r));
        net_acc_r   <= sat_add64(net_acc_r, e_term_r);
        if (e_price_r < min_acc_r) begin
          min_acc_r <= e_price_r;
        end
        if (e_price_r > max_acc_r) begin
          max_acc_r <= e_price_r;
        end
      end
    end
  end

  assign avg_mag = price_acc_r[SUM_W-1] ? (~price_acc_r + 1'b1) : price_acc_r;

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      avg_neg_r <= price_acc_r[SUM_W-1];
    end
  end

  cae_div #(
    .DIVISOR_BITS(COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (avg_mag),
    .divisor  (count_acc_r),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    if (count_acc_r == '0) begin
      avg_val = '0;
    end else if (avg_neg_r) begin
      avg_val = (quotient > AVG_NEG_LIM) ? S32_MIN : PRICE_W'(~quotient + 1'b1);
    end else begin
      avg_val = (quotient > AVG_POS_LIM) ? S32_MAX : quotient[PRICE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_count_r <= count_acc_r;
      out_psum_r  <= price_acc_r;
      out_min_r   <= min_acc_r;
      out_max_r   <= max_acc_r;
      out_avg_r   <= avg_val;
      out_qsum_r  <= qty_acc_r;
      out_nsum_r  <= net_acc_r;
    end
  end

  assign status.last_done  = last_done_r;
  assign status.div_done   = div_done;
  assign out_sel_count     = out_count_r;
  assign out_price_sum     = $signed(out_psum_r);
  assign out_price_min     = out_min_r;
  assign out_price_max     = out_max_r;
  assign out_price_avg     = $signed(out_avg_r);
  assign out_quantity_sum  = $signed(out_qsum_r);
  assign out_net_sales_sum = $signed(out_nsum_r);

endmodule

[design/cae_ctrl.sv]
// controller: row intake, drain after the last row, divide, result handoff
module cae_ctrl import cae_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_last_row,
  input  logic        out_ready,
  input  cae_status_t status,
  output logic        in_ready,
  output logic        out_valid,
  output cae_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_ready_nxt  = in_ready_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      ST_ACCUM: begin
        if (in_valid && in_ready_r && in_last_row) begin
          in_ready_nxt = 1'b0;
          state_nxt    = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // accumulators already hold the last row
        if (status.last_done) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          in_ready_nxt  = 1'b1;
          state_nxt     = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

endmodule

[bench/column_aggregate_engine_tb.sv]
`timescale 1ns / 100ps
// self-checking bench for column_aggregate_engine: directed and random row streams
module column_aggregate_engine_tb import cae_pkg::*; ();

  localparam int COUNT_BITS  = 40;
  localparam int DFB         = 16;
  localparam logic [DFB:0] DISC_ONE = {1'b1, {DFB{1'b0}}};
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 120;

  typedef struct packed {
    logic signed [PRICE_W-1:0] price;
    logic [DFB:0]              discount;
    logic signed [QTY_W-1:0]   quantity;
    logic                      selected;
    logic                      last_row;
  } row_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0]     sel_count;
    logic signed [SUM_W-1:0]   price_sum;
    logic signed [PRICE_W-1:0] price_min;
    logic signed [PRICE_W-1:0] price_max;
    logic signed [PRICE_W-1:0] price_avg;
    logic signed [SUM_W-1:0]   quantity_sum;
    logic signed [SUM_W-1:0]   net_sales_sum;
  } totals_t;

  logic clk = 1'b0;
  logic rst_n;

  cae_in_if  #(.DISCOUNT_FRAC_BITS(DFB)) in_ch ();
  cae_out_if #(.COUNT_BITS(COUNT_BITS))  out_ch ();

  column_aggregate_engine #(
    .COUNT_BITS(COUNT_BITS),
    .DISCOUNT_FRAC_BITS(DFB)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  totals_t running;
  totals_t pending_totals[$];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_reqs      = 0;
  int fail_count     = 0;
  int quiet_cycles   = 0;

  always #10 clk = ~clk;

  function automatic void clear_running();
    running = '0;
    running.price_min = S32_MAX;
    running.price_max = S32_MIN;
  endfunction

  function automatic logic signed [SUM_W-1:0] add_sat(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0] s;
    s = a + b;
    if (s > $signed({1'b0, S64_MAX})) return S64_MAX;
    if (s < $signed({1'b1, S64_MIN})) return S64_MIN;
    return s[SUM_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] net_term(input row_t r);
    logic signed [95:0] price_x, keep_x, qty_x, prod;
    logic [DFB:0] disc;
    disc    = (r.discount > DISC_ONE) ? DISC_ONE : r.discount;
    price_x = $signed(r.price);
    keep_x  = $signed({{(96-DFB-1){1'b0}}, DISC_ONE - disc});
    qty_x   = $signed(r.quantity);
    // arithmetic shift floors toward minus infinity
    prod = (price_x * keep_x * qty_x) >>> DFB;
    if (prod > $signed({32'd0, S64_MAX})) return S64_MAX;
    if (prod < $signed({{32{1'b1}}, S64_MIN})) return S64_MIN;
    return prod[SUM_W-1:0];
  endfunction

  function automatic void fold_row(input row_t r);
    totals_t t;
    logic signed [SUM_W:0] quot;
    if (r.selected) begin
      if (running.sel_count != '1) running.sel_count++;
      running.price_sum = add_sat(running.price_sum, $signed(r.price));
      if ($signed(r.price) < $signed(running.price_min)) running.price_min = r.price;
      if ($signed(r.price) > $signed(running.price_max)) running.price_max = r.price;
      running.quantity_sum  = add_sat(running.quantity_sum, $signed(r.quantity));
      running.net_sales_sum = add_sat(running.net_sales_sum, net_term(r));
    end
    if (r.last_row) begin
      t = running;
      if (t.sel_count == '0) begin
        t.price_avg = '0;
      end else begin
        quot = $signed({t.price_sum[SUM_W-1], t.price_sum}) /
               $signed({{(SUM_W+1-COUNT_BITS){1'b0}}, t.sel_count});
        if (quot > $signed({33'd0, S32_MAX})) t.price_avg = S32_MAX;
        else if (quot < $signed({{33{1'b1}}, S32_MIN})) t.price_avg = S32_MIN;
        else t.price_avg = quot[PRICE_W-1:0];
      end
      pending_totals.push_back(t);
      clear_running();
    end
  endfunction

  function automatic row_t mk_row(input logic [31:0] price, input logic [DFB:0] disc,
                                  input logic [31:0] qty, input bit sel, input bit last_row);
    row_t r;
    r.price    = price;
    r.discount = disc;
    r.quantity = qty;
    r.selected = sel;
    r.last_row = last_row;
    return r;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2:       return $urandom_range(0, 2) - 1;
      3, 4:    return $urandom;
      default: return $urandom_range(0, 200000) - 100000;
    endcase
  endfunction

  function automatic logic [DFB:0] pick_discount();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return DISC_ONE;
      2:       return (DFB+1)'($urandom_range(DISC_ONE + 1, 2 * DISC_ONE - 1));
      3:       return (DFB+1)'($urandom_range(0, 2 * DISC_ONE - 1));
      default: return (DFB+1)'($urandom_range(0, DISC_ONE));
    endcase
  endfunction

  // one row word, with random idle cycles ahead of it
  task automatic send_row(input row_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.price    <= r.price;
    in_ch.discount <= r.discount;
    in_ch.quantity <= r.quantity;
    in_ch.selected <= r.selected;
    in_ch.last_row <= r.last_row;
    do @(posedge clk); while (!in_ch.ready);
    fold_row(r);
  endtask

  // receiver: random stalls, plus a long hold whenever one is requested
  initial begin : receiver
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_served) begin
        hold_served = hold_reqs;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= 10) $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    totals_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_totals.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result word with none expected, sel_count %0d",
                                       out_ch.sel_count);
      end else begin
        want = pending_totals.pop_front();
        check_field("sel_count", 64'(want.sel_count), 64'(out_ch.sel_count));
        check_field("price_sum", want.price_sum, out_ch.price_sum);
        check_field("price_min", 64'(want.price_min), 64'(out_ch.price_min));
        check_field("price_max", 64'(want.price_max), 64'(out_ch.price_max));
        check_field("price_avg", 64'(want.price_avg), 64'(out_ch.price_avg));
        check_field("quantity_sum", want.quantity_sum, out_ch.quantity_sum);
        check_field("net_sales_sum", want.net_sales_sum, out_ch.net_sales_sum);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_empty_selection();
    send_row(mk_row(S32_MIN, '0, S32_MAX, 1'b0, 1'b1));
  endtask

  task automatic test_unselected_last();
    send_row(mk_row(32'd1234, 17'd100, 32'd7, 1'b1, 1'b0));
    send_row(mk_row(S32_MAX, '0, S32_MAX, 1'b0, 1'b1));
  endtask

  task automatic test_field_extremes();
    send_row(mk_row(S32_MAX, '0, S32_MAX, 1'b1, 1'b0));
    send_row(mk_row(S32_MIN, DISC_ONE, S32_MIN, 1'b1, 1'b0));
    send_row(mk_row(32'd0, 17'd1, 32'hFFFF_FFFF, 1'b1, 1'b0));
    // -1 times one unit must floor to -1
    send_row(mk_row(32'hFFFF_FFFF, DISC_ONE - 1'b1, 32'd1, 1'b1, 1'b0));
    send_row(mk_row(32'd1, 17'd1, 32'd1, 1'b1, 1'b1));
    send_row(mk_row(S32_MIN, '0, 32'd1, 1'b1, 1'b1));
    send_row(mk_row(S32_MAX, DISC_ONE - 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
  endtask

  task automatic test_discount_range();
    send_row(mk_row(32'd1000, DISC_ONE + 1'b1, 32'd3, 1'b1, 1'b0));
    send_row(mk_row(32'd1000, '1, 32'hFFFF_FFFD, 1'b1, 1'b0));
    send_row(mk_row(-32'sd1000, DISC_ONE, 32'd3, 1'b1, 1'b0));
    send_row(mk_row(32'd1000, DISC_ONE - 1'b1, 32'd3, 1'b1, 1'b1));
  endtask

  task automatic test_net_saturation();
    // two terms of 2^62 hit the positive limit, a negative one pulls back
    send_row(mk_row(S32_MIN, '0, S32_MIN, 1'b1, 1'b0));
    send_row(mk_row(S32_MIN, '0, S32_MIN, 1'b1, 1'b0));
    send_row(mk_row(S32_MIN, '0, S32_MAX, 1'b1, 1'b1));
    send_row(mk_row(S32_MIN, '0, S32_MAX, 1'b1, 1'b0));
    send_row(mk_row(S32_MIN, '0, S32_MAX, 1'b1, 1'b0));
    send_row(mk_row(S32_MIN, '0, S32_MAX, 1'b1, 1'b1));
  endtask

  task automatic test_random_queries(input int rows, input int idle_pct, input int stall_pct);
    int sent, len, sel_pct;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < rows) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      case ($urandom_range(0, 7))
        0:       sel_pct = 0;
        1:       sel_pct = 100;
        default: sel_pct = $urandom_range(20, 90);
      endcase
      for (int i = 0; i < len; i++) begin
        send_row(mk_row(pick_word(), pick_discount(), pick_word(),
                        $urandom_range(0, 99) < sel_pct, i == len - 1));
      end
      sent += len;
    end
  endtask

  // short queries pile up behind a held result until intake stalls
  task automatic test_output_backpressure();
    int len;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_reqs++;
    for (int q = 0; q < 12; q++) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        send_row(mk_row(pick_word(), pick_discount(), pick_word(),
                        $urandom_range(0, 3) != 0, i == len - 1));
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.price    = '0;
    in_ch.discount = '0;
    in_ch.quantity = '0;
    in_ch.selected = 1'b0;
    in_ch.last_row = 1'b0;
    clear_running();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_selection();
    test_unselected_last();
    test_field_extremes();
    test_discount_range();
    test_net_saturation();
    test_random_queries(530, 23, 83);
    test_random_queries(530, 83, 23);
    test_output_backpressure();
    test_random_queries(530, 0, 0);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
